// ===== hw/rtl/tdp_pkg.sv =====
`timescale 1ns / 1ps

package tdp_pkg;

	// sequencer states, one-hot
	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_CHECK  = 5'b00010,
		ST_DIV    = 5'b00100,
		ST_TEST   = 5'b01000,
		ST_FINISH = 5'b10000
	} tdp_state_t;

	// verdict codes
	localparam logic VERDICT_COMPOSITE = 1'b0;
	localparam logic VERDICT_PRIME     = 1'b1;

endpackage

// ===== hw/rtl/trial_division_primality_core.sv =====
`timescale 1ns / 1ps

// Trial-division primality tester. One signed value is taken per beat and one
// is_prime bit comes back for it; negative values, zero and one give 0. The
// core tries divisors 2, 3, 4, ... while the divisor squared does not exceed
// the value, keeping the square up to date with one add per divisor. Each
// remainder comes from a bit-serial restoring loop that shares one subtractor
// and retires one bit per cycle; each divisor takes a bound check,
// VALUE_WIDTH - 1 remainder steps and a zero test. Up to about 46341
// divisors are tried for a 32-bit prime. in_ready is high only between
// items; a finished result waits in the output register while the next
// value is taken.
module trial_division_primality_core #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [VALUE_WIDTH-1:0] value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          is_prime
);
	import tdp_pkg::*;

	localparam int DW = VALUE_WIDTH / 2 + 1;
	localparam int CW = $clog2(VALUE_WIDTH);
	localparam int PW = VALUE_WIDTH - DW - 1;

	tdp_state_t             state_q;
	logic [VALUE_WIDTH-1:0] n_q;
	logic [VALUE_WIDTH-1:0] sq_q;
	logic [DW-1:0]          d_q;
	logic [DW-1:0]          rem_q;
	logic [CW-1:0]          cnt_q;
	logic                   res_q;
	logic                   out_valid_q;
	logic                   is_prime_q;

	logic                   below_two;
	logic [DW:0]            trial;
	logic [DW:0]            diff;
	logic [DW-1:0]          rem_next;
	logic [VALUE_WIDTH-1:0] sq_step;
	logic                   out_free;

	// values below two: sign set, or all bits above bit 0 clear
	assign below_two = value[VALUE_WIDTH-1] || (value[VALUE_WIDTH-1:1] == '0);

	// shared subtractor of the restoring remainder loop
	assign trial    = {rem_q, n_q[cnt_q]};
	assign diff     = trial - {1'b0, d_q};
	assign rem_next = diff[DW] ? trial[DW-1:0] : diff[DW-1:0];

	// (d+1)^2 = d^2 + 2d + 1
	assign sq_step = {{PW{1'b0}}, d_q, 1'b1};

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign is_prime  = is_prime_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= below_two ? ST_FINISH : ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_q <= (sq_q > n_q) ? ST_FINISH : ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_TEST;
					end
				end
				ST_TEST: begin
					state_q <= (rem_q == '0) ? ST_FINISH : ST_CHECK;
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					n_q   <= value;
					d_q   <= DW'(2);
					sq_q  <= VALUE_WIDTH'(4);
					res_q <= VERDICT_COMPOSITE;
				end
			end
			ST_CHECK: begin
				if (sq_q > n_q) begin
					res_q <= VERDICT_PRIME;
				end
				rem_q <= '0;
				cnt_q <= CW'(VALUE_WIDTH - 2);
			end
			ST_DIV: begin
				rem_q <= rem_next;
				cnt_q <= cnt_q - CW'(1);
			end
			ST_TEST: begin
				if (rem_q != '0) begin
					d_q  <= d_q + DW'(1);
					sq_q <= sq_q + sq_step;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					is_prime_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	// restoring loop keeps the partial remainder below the divisor
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TEST) |-> (rem_q < d_q))
		else $error("partial remainder not below divisor");

	// trial divisor never drops below two while working
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK || state_q == ST_DIV || state_q == ST_TEST) |-> (d_q >= DW'(2)))
		else $error("trial divisor below two");

	// a finished verdict waits while the previous result is still held
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && out_valid_q && !out_ready) |=> (state_q == ST_FINISH))
		else $error("verdict overwrote an untaken result");

	// a prime verdict only follows a failed bound check
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK && sq_q <= n_q) |=> (state_q == ST_DIV && res_q == VERDICT_COMPOSITE))
		else $error("prime verdict taken with divisors left");

endmodule

// ===== verif/trial_division_primality_core_tb.sv =====
`timescale 1ns / 1ps

module trial_division_primality_core_tb;

	import tdp_pkg::*;

	localparam int VALUE_WIDTH = 32;
	// longest quiet stretch of a correct run: a prime near 2^20 tries about
	// 1024 divisors, plus the longest stalls on both sides
	localparam int STUCK_LIMIT = 300000;
	localparam int DRAIN_CYCLES = 200;
	localparam int RANDOM_ITEMS = 75;

	typedef struct {
		logic signed [VALUE_WIDTH-1:0] num;
		bit                            drain;
	} pending_t;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	logic signed [VALUE_WIDTH-1:0] value;
	logic                          out_valid;
	logic                          out_ready;
	logic                          is_prime;

	pending_t pending_q[$];
	logic     verdict_fifo[$];
	int       send_wait;
	int       recv_wait;
	int       recv_draw;
	int       stuck_cycles;
	int       mismatch_count;
	int       sent_count;
	int       got_count;
	int       prime_count;
	bit       burst_mode;

	trial_division_primality_core #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.value    (value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.is_prime (is_prime)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// verdict by trial division, divisor bound kept as d <= n / d
	function automatic logic prime_verdict(logic signed [VALUE_WIDTH-1:0] v);
		longint unsigned n;
		longint unsigned d;
		if (v < 2)
			return VERDICT_COMPOSITE;
		n = longint'(v);
		for (d = 2; d <= n / d; d++) begin
			if (n % d == 0)
				return VERDICT_COMPOSITE;
		end
		return VERDICT_PRIME;
	endfunction

	// idle cycles per beat, with occasional stretches of no idling at all
	function automatic int idle_draw();
		if ($urandom_range(0, 11) == 0)
			burst_mode = ~burst_mode;
		return burst_mode ? 0 : int'($urandom_range(0, 17));
	endfunction

	task automatic report_mismatch(string what);
		mismatch_count++;
		$display("mismatch at %0t: %s", $realtime, what);
	endtask

	task automatic queue_item(logic signed [VALUE_WIDTH-1:0] num, bit drain = 1'b0);
		pending_t item;
		item.num = num;
		item.drain = drain;
		pending_q.push_back(item);
	endtask

	// driver: one beat per pending item, a flagged item waits until all verdicts are in
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			value <= '0;
			send_wait <= 0;
		end else begin
			if (in_valid && in_ready) begin
				verdict_fifo.push_back(prime_verdict(value));
				sent_count++;
			end
			if (in_valid && !in_ready) begin
				// beat still pending, hold it
			end else if (send_wait != 0) begin
				in_valid <= 1'b0;
				send_wait <= send_wait - 1;
			end else if (pending_q.size() != 0 &&
					!(pending_q[0].drain && verdict_fifo.size() != 0)) begin
				in_valid <= 1'b1;
				value <= pending_q[0].num;
				void'(pending_q.pop_front());
				send_wait <= idle_draw();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: compare each verdict with the oldest expectation, stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_wait <= 0;
		end else begin
			if (out_valid && out_ready) begin
				got_count++;
				if (verdict_fifo.size() == 0) begin
					report_mismatch($sformatf("is_prime=%b with no item outstanding", is_prime));
				end else begin
					if (is_prime !== verdict_fifo[0])
						report_mismatch($sformatf("is_prime=%b, expected %b",
							is_prime, verdict_fifo[0]));
					if (verdict_fifo[0] == VERDICT_PRIME)
						prime_count++;
					void'(verdict_fifo.pop_front());
				end
				recv_draw = idle_draw();
				recv_wait <= recv_draw;
				out_ready <= (recv_draw == 0);
			end else if (recv_wait != 0) begin
				recv_wait <= recv_wait - 1;
				out_ready <= (recv_wait == 1);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stuck_cycles <= 0;
		end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= STUCK_LIMIT) begin
			$display("no beat for %0d cycles", STUCK_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	// stimulus and end of run
	initial begin
		int unsigned pick;
		int unsigned big;
		arst_n = 1'b0;
		burst_mode = 1'b0;
		mismatch_count = 0;
		sent_count = 0;
		got_count = 0;
		prime_count = 0;

		// directed: below two, negatives, extremes, squares of primes, known primes
		queue_item(0);
		queue_item(1);
		queue_item(2);
		queue_item(3);
		queue_item(4);
		queue_item(5);
		queue_item(-1);
		queue_item(-2);
		queue_item(32'sh8000_0000);
		queue_item(32'sh8000_0001);
		queue_item(32'shAAAA_AAAA);
		queue_item(32'sh7FFF_FFFE);
		queue_item(32'sh7FFF_FFFD);
		queue_item(32'sh5555_5555);
		queue_item(32'sh2AAA_AAAA);
		queue_item(9);
		queue_item(25);
		queue_item(49);
		queue_item(169);
		queue_item(97);
		queue_item(65521);
		queue_item(65535);
		queue_item(1048573, 1'b1);
		queue_item(1048576);
		queue_item(32'sh4000_0001);

		// random: mostly small values so primes are common and quick
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				queue_item($urandom_range(0, 4095), i == 0 || $urandom_range(0, 39) == 0);
			end else if (pick < 70) begin
				queue_item($urandom_range(4096, 1 << 20));
			end else if (pick < 82) begin
				queue_item(32'sh8000_0000 | $urandom());
			end else if (pick < 95) begin
				// wide values kept to a small factor so each one ends fast
				big = $urandom_range(3, 32'h7FFF_FFFF);
				big = $urandom_range(0, 1) ? (big & ~32'd1) : (big - big % 3);
				queue_item(big);
			end else begin
				queue_item(int'($urandom_range(0, 6)) - 3);
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_q.size() != 0 || in_valid || verdict_fifo.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d values sent, %0d verdicts checked, %0d of them prime", sent_count,
			got_count, prime_count);
		$display("covered values below two, negatives, squares of primes, wide composites");
		if (mismatch_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== trial_division_primality_core.f =====
hw/rtl/tdp_pkg.sv
hw/rtl/trial_division_primality_core.sv
verif/trial_division_primality_core_tb.sv
